/* src/ttcs_pkg.sv */
// ----------------------------------------------------------------------------
// ttcs_pkg
// Shared types and constants of the tick timeout compare scheduler.
// ----------------------------------------------------------------------------
package ttcs_pkg;

  localparam int unsigned CPT_W = 24;
  localparam int unsigned WORD_W = 32;

  localparam logic [CPT_W-1:0] CPT_RESET = 24'd160000;
  localparam logic [WORD_W-1:0] LEAD_CYCLES = 32'd64;
  localparam logic [WORD_W-1:0] ALIGN_ADD = 32'd7;
  localparam logic [WORD_W-1:0] ALIGN_MASK = 32'h0000_0007;
  localparam logic [WORD_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TICKS_FOREVER = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_INTERRUPT   = 2'd0,
    OP_SET_TIMEOUT = 2'd1,
    OP_QUERY       = 2'd2
  } op_t;

  typedef enum logic {
    REG_TICK_LENGTH   = 1'b0,
    REG_TICKLESS_MODE = 1'b1
  } reg_index_t;

  // Lead of at least LEAD_CYCLES over now, then round up to a multiple of 8.
  function automatic logic [WORD_W-1:0] make_compare(input logic [WORD_W-1:0] cmp,
                                                     input logic [WORD_W-1:0] now);
    logic [WORD_W-1:0] lead;
    logic [WORD_W-1:0] c;
    lead = cmp - now;
    c = (lead < LEAD_CYCLES) ? (now + LEAD_CYCLES) : cmp;
    return (c + ALIGN_ADD) & ~ALIGN_MASK;
  endfunction

endpackage

/* src/ttcs_div.sv */
// ----------------------------------------------------------------------------
// ttcs_div
// Restoring divider, one quotient bit per cycle, 32-bit word by tick length.
// ----------------------------------------------------------------------------
module ttcs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ttcs_pkg::WORD_W-1:0]  dividend,
  input  logic [ttcs_pkg::CPT_W-1:0]   divisor,
  output logic                         done,
  output logic [ttcs_pkg::WORD_W-1:0]  quotient
);

  localparam int unsigned CNT_W = $clog2(ttcs_pkg::WORD_W);

  logic                         active;
  logic [CNT_W-1:0]             count;
  logic [ttcs_pkg::CPT_W-1:0]   rem;
  logic [ttcs_pkg::WORD_W-1:0]  quo;
  logic [ttcs_pkg::CPT_W-1:0]   dvs;

  logic [ttcs_pkg::CPT_W:0]     partial;
  logic [ttcs_pkg::CPT_W+1:0]   trial;
  logic                         ge;
  logic [ttcs_pkg::CPT_W-1:0]   rem_next;

  assign partial = {rem, quo[ttcs_pkg::WORD_W-1]};
  assign trial = {1'b0, partial} - {2'b00, dvs};
  assign ge = ~trial[ttcs_pkg::CPT_W+1];
  assign rem_next = ge ? trial[ttcs_pkg::CPT_W-1:0] : partial[ttcs_pkg::CPT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= active && (count == '0);
      if (start) begin
        active <= 1'b1;
        count <= CNT_W'(ttcs_pkg::WORD_W - 1);
      end else if (active) begin
        count <= count - 1'b1;
        if (count == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (active) begin
      rem <= rem_next;
      quo <= {quo[ttcs_pkg::WORD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

/* src/tick_timeout_compare_scheduler.sv */
// ----------------------------------------------------------------------------
// tick_timeout_compare_scheduler
// Turns kernel timer events into tick counts and aligned compare values.
// ----------------------------------------------------------------------------
// Usage: each input word carries an operation in s_tuser and the counter value
// and requested ticks in s_tdata. Every accepted word gives exactly one output
// word. The block takes one word at a time; s_tready is high only while idle.
// One shared restoring divider and a registered 32 by 24 multiplier do the work:
//   interrupt: divide, multiply, announce, plus a compare step in periodic mode.
//   query, tickless: divide; otherwise and unused codes: straight to done.
//   set timeout, tickless: divide, multiply, saturate, divide, multiply, base,
//   compare (two divisions); periodic: straight to done.
// The result goes to an output register, so the next word is taken while a
// result still waits on m_tready. If the receiver stalls with a result already
// held, the sequencer holds its finished result until the register frees.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, as the block does not enforce this. Reset clears the
// announce point to zero, sets the tick length to 160000 and selects tickless mode.
// ----------------------------------------------------------------------------
module tick_timeout_compare_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // now[31:0], ticks[63:32]
  input  logic [1:0]                  s_tuser,   // operation[1:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,   // compare_value[31:0], tick_count[63:32]
  output logic [1:0]                  m_tuser,   // compare_write[0], announce_valid[1]
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [ttcs_pkg::CPT_W-1:0]  cfg_data
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_EL_DIV   = 12'b0000_0000_0010,
    ST_EL_MUL   = 12'b0000_0000_0100,
    ST_ANNOUNCE = 12'b0000_0000_1000,
    ST_MAX_DIV  = 12'b0000_0001_0000,
    ST_T_MUL    = 12'b0000_0010_0000,
    ST_SATURATE = 12'b0000_0100_0000,
    ST_Q_DIV    = 12'b0000_1000_0000,
    ST_Q_MUL    = 12'b0001_0000_0000,
    ST_BASE     = 12'b0010_0000_0000,
    ST_COMPARE  = 12'b0100_0000_0000,
    ST_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  logic [ttcs_pkg::CPT_W-1:0]   tick_length;
  logic                         tickless_mode;
  logic [ttcs_pkg::WORD_W-1:0]  last_announce;

  ttcs_pkg::op_t                op_r;
  logic [ttcs_pkg::WORD_W-1:0]  now_r;
  logic [ttcs_pkg::WORD_W-1:0]  ticks_r;
  logic [ttcs_pkg::CPT_W-1:0]   cpt_r;
  logic                         mode_r;
  logic [ttcs_pkg::WORD_W-1:0]  diff_r;
  logic [ttcs_pkg::WORD_W-1:0]  adj_r;
  logic [ttcs_pkg::WORD_W-1:0]  cmp_base;
  logic [ttcs_pkg::WORD_W-1:0]  mul_a;
  logic [ttcs_pkg::WORD_W-1:0]  prod;
  logic [ttcs_pkg::WORD_W+ttcs_pkg::CPT_W-1:0] prod_wide;

  logic                         res_cw;
  logic [ttcs_pkg::WORD_W-1:0]  res_cv;
  logic                         res_av;
  logic [ttcs_pkg::WORD_W-1:0]  res_tc;

  ttcs_pkg::op_t                in_op;
  logic [ttcs_pkg::WORD_W-1:0]  in_diff;
  logic [ttcs_pkg::CPT_W-1:0]   in_cpt;
  logic                         accept;
  logic                         slot_free;

  logic                         div_start;
  logic [ttcs_pkg::WORD_W-1:0]  div_dividend;
  logic [ttcs_pkg::CPT_W-1:0]   div_divisor;
  logic                         div_done;
  logic [ttcs_pkg::WORD_W-1:0]  div_quo;

  logic [ttcs_pkg::WORD_W-1:0]  el_fix;
  logic [ttcs_pkg::WORD_W-1:0]  ticks_m1;
  logic [ttcs_pkg::WORD_W-1:0]  t_clamp;
  logic [ttcs_pkg::WORD_W:0]    sat_sum;
  logic [ttcs_pkg::WORD_W-1:0]  sat_cycles;

  assign in_op = ttcs_pkg::op_t'(s_tuser);
  assign in_diff = s_tdata[31:0] - last_announce;
  assign in_cpt = (tick_length == '0) ? ttcs_pkg::CPT_W'(1) : tick_length;
  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  assign el_fix = (div_quo == '0) ? ttcs_pkg::WORD_W'(1) : div_quo;
  assign ticks_m1 = ticks_r - 1'b1;

  always_comb begin
    if (ticks_r == ttcs_pkg::TICKS_FOREVER) begin
      t_clamp = (div_quo == '0) ? '0 : (div_quo - 1'b1);
    end else if (ticks_r[ttcs_pkg::WORD_W-1] || (ticks_r == '0)) begin
      t_clamp = '0;
    end else if (ticks_m1 > div_quo) begin
      t_clamp = div_quo;
    end else begin
      t_clamp = ticks_m1;
    end
  end

  assign sat_sum = {1'b0, prod} + {1'b0, adj_r};
  assign sat_cycles = sat_sum[ttcs_pkg::WORD_W] ? '1 : sat_sum[ttcs_pkg::WORD_W-1:0];

  assign prod_wide = mul_a * cpt_r;

  ttcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_dividend = in_diff;
    div_divisor = cpt_r;
    case (state)
      ST_IDLE: begin
        div_divisor = in_cpt;
        if (s_tvalid) begin
          case (in_op)
            ttcs_pkg::OP_INTERRUPT: begin
              div_start = 1'b1;
              state_next = ST_EL_DIV;
            end
            ttcs_pkg::OP_QUERY: begin
              if (tickless_mode) begin
                div_start = 1'b1;
                state_next = ST_EL_DIV;
              end else begin
                state_next = ST_DONE;
              end
            end
            ttcs_pkg::OP_SET_TIMEOUT: begin
              if (tickless_mode) begin
                div_start = 1'b1;
                div_dividend = ttcs_pkg::HALF_RANGE;
                state_next = ST_MAX_DIV;
              end else begin
                state_next = ST_DONE;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_EL_DIV: begin
        if (div_done) begin
          state_next = (op_r == ttcs_pkg::OP_QUERY) ? ST_DONE : ST_EL_MUL;
        end
      end
      ST_EL_MUL: state_next = ST_ANNOUNCE;
      ST_ANNOUNCE: state_next = mode_r ? ST_DONE : ST_COMPARE;
      ST_MAX_DIV: begin
        if (div_done) begin
          state_next = ST_T_MUL;
        end
      end
      ST_T_MUL: state_next = ST_SATURATE;
      ST_SATURATE: begin
        div_start = 1'b1;
        div_dividend = sat_cycles;
        state_next = ST_Q_DIV;
      end
      ST_Q_DIV: begin
        if (div_done) begin
          state_next = ST_Q_MUL;
        end
      end
      ST_Q_MUL: state_next = ST_BASE;
      ST_BASE: state_next = ST_COMPARE;
      ST_COMPARE: state_next = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tick_length <= ttcs_pkg::CPT_RESET;
      tickless_mode <= 1'b1;
      last_announce <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (ttcs_pkg::reg_index_t'(cfg_index))
          ttcs_pkg::REG_TICK_LENGTH: tick_length <= cfg_data;
          ttcs_pkg::REG_TICKLESS_MODE: tickless_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == ST_ANNOUNCE) begin
        last_announce <= last_announce + prod;
      end
      if ((state == ST_DONE) && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_wide[ttcs_pkg::WORD_W-1:0];
    if (accept) begin
      op_r <= in_op;
      now_r <= s_tdata[31:0];
      ticks_r <= s_tdata[63:32];
      cpt_r <= in_cpt;
      mode_r <= tickless_mode;
      diff_r <= in_diff;
      res_cw <= 1'b0;
      res_cv <= '0;
      res_av <= 1'b0;
      res_tc <= '0;
    end
    if ((state == ST_EL_DIV) && div_done) begin
      mul_a <= el_fix;
      if (op_r == ttcs_pkg::OP_QUERY) begin
        res_tc <= div_quo;
      end
    end
    if (state == ST_ANNOUNCE) begin
      cmp_base <= last_announce + prod + {{(ttcs_pkg::WORD_W-ttcs_pkg::CPT_W){1'b0}}, cpt_r};
      res_av <= 1'b1;
      res_tc <= mode_r ? mul_a : ttcs_pkg::WORD_W'(1);
    end
    if ((state == ST_MAX_DIV) && div_done) begin
      mul_a <= t_clamp;
      adj_r <= diff_r + {{(ttcs_pkg::WORD_W-ttcs_pkg::CPT_W){1'b0}}, cpt_r} - 1'b1;
    end
    if ((state == ST_Q_DIV) && div_done) begin
      mul_a <= div_quo;
    end
    if (state == ST_BASE) begin
      cmp_base <= last_announce + prod;
    end
    if (state == ST_COMPARE) begin
      res_cw <= 1'b1;
      res_cv <= ttcs_pkg::make_compare(cmp_base, now_r);
    end
    if ((state == ST_DONE) && slot_free) begin
      m_tdata <= {res_tc, res_cv};
      m_tuser <= {res_av, res_cw};
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != ST_IDLE))
    else $error("accepted word did not start a sequence");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_EL_DIV || state == ST_MAX_DIV || state == ST_Q_DIV))
    else $error("divider finished outside a division step");

  a_done_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE && $stable(m_tdata)))
    else $error("held result overwritten while output stalled");
`endif

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the tick timeout compare scheduler against a behavioral predictor.
// Timer events (interrupts, timeout requests, elapsed queries and the unused
// code) are streamed in under random backpressure on both sides, across
// several tick lengths and both kernel modes, and every output word is
// compared field by field with the predicted outcome.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_AT = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 100;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] ticks;
  } timer_event_t;

  typedef struct packed {
    logic        cmp_write;
    logic [31:0] cmp_value;
    logic        announce;
    logic [31:0] count;
  } timer_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [ttcs_pkg::CPT_W-1:0] cfg_data = '0;

  logic [ttcs_pkg::CPT_W-1:0] tick_length = ttcs_pkg::CPT_RESET;
  logic tickless = 1'b1;
  logic [31:0] announce_point = '0;
  logic [31:0] sim_clock = '0;

  timer_event_t timer_events[$];
  timer_outcome_t outcomes_due[$];
  timer_event_t offered;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  bit quiet = 0;
  int results_seen = 0;
  int mismatches = 0;
  longint cycle_count = 0;

  tick_timeout_compare_scheduler DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] effective_length();
    return (tick_length == '0) ? 32'd1 : {8'd0, tick_length};
  endfunction

  function automatic logic [31:0] aligned_compare(input logic [31:0] target,
                                                  input logic [31:0] now);
    logic [31:0] lead;
    logic [31:0] c;
    lead = target - now;
    c = (lead < ttcs_pkg::LEAD_CYCLES) ? now + ttcs_pkg::LEAD_CYCLES : target;
    c = c + 32'd7;
    return c & ~ttcs_pkg::ALIGN_MASK;
  endfunction

  function automatic timer_outcome_t timer_event_outcome(input timer_event_t ev);
    timer_outcome_t r;
    logic [31:0] len;
    logic [31:0] tick_limit;
    logic [31:0] since;
    logic [31:0] whole;
    logic [31:0] adjust;
    logic [31:0] cycles;
    longint t;
    r = '0;
    len = effective_length();
    tick_limit = ttcs_pkg::HALF_RANGE / len;
    since = ev.now - announce_point;
    case (ev.op)
      ttcs_pkg::OP_INTERRUPT: begin
        whole = since / len;
        if (whole == 0) whole = 1;
        announce_point = announce_point + whole * len;
        if (!tickless) begin
          r.cmp_write = 1'b1;
          r.cmp_value = aligned_compare(announce_point + len, ev.now);
        end
        r.announce = 1'b1;
        r.count = tickless ? whole : 32'd1;
      end
      ttcs_pkg::OP_SET_TIMEOUT: begin
        if (tickless) begin
          t = $signed(ev.ticks);
          if (ev.ticks == ttcs_pkg::TICKS_FOREVER) t = longint'(tick_limit);
          t = t - 1;
          if (t < 0) t = 0;
          if (t > longint'(tick_limit)) t = longint'(tick_limit);
          adjust = since + (len - 32'd1);
          cycles = t[31:0] * len;
          if (cycles <= 32'hFFFF_FFFF - adjust) cycles = cycles + adjust;
          else cycles = 32'hFFFF_FFFF;
          cycles = (cycles / len) * len;
          r.cmp_write = 1'b1;
          r.cmp_value = aligned_compare(announce_point + cycles, ev.now);
        end
      end
      ttcs_pkg::OP_QUERY: begin
        r.count = tickless ? since / len : 32'd0;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender side.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        outcomes_due.push_back(timer_event_outcome(offered));
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (timer_events.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          s_tvalid <= 1'b0;
        end else if (timer_events.size() > 0) begin
          offered = timer_events.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {offered.ticks, offered.now};
          s_tuser <= offered.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver side.
  always @(posedge clk) begin
    timer_outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (outcomes_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual user %b data %h",
                   $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("compare_write", {31'd0, want.cmp_write}, {31'd0, m_tuser[0]});
          check_field("compare_value", want.cmp_value, m_tdata[31:0]);
          check_field("announce_valid", {31'd0, want.announce}, {31'd0, m_tuser[1]});
          check_field("tick_count", want.count, m_tdata[63:32]);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (timer_events.size() != 0 || s_tvalid || outcomes_due.size() != 0);
  endtask

  task automatic write_reg(input ttcs_pkg::reg_index_t idx,
                           input logic [ttcs_pkg::CPT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == ttcs_pkg::REG_TICK_LENGTH) tick_length = value;
    else tickless = value[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_event(input logic [1:0] op, input logic [31:0] now,
                           input logic [31:0] ticks);
    timer_event_t ev;
    ev.op = op;
    ev.now = now;
    ev.ticks = ticks;
    timer_events.push_back(ev);
  endtask

  // Time mostly moves forward by a few ticks, so the announce point stays
  // close to now; occasional jumps land anywhere in the counter range.
  task automatic add_events(input int count);
    logic [31:0] len;
    logic [31:0] tick_limit;
    logic [31:0] ticks;
    logic [1:0] op;
    int unsigned pick;
    len = effective_length();
    tick_limit = ttcs_pkg::HALF_RANGE / len;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) sim_clock = sim_clock + $urandom_range(0, 3 * len);
      else if (pick < 75) sim_clock = sim_clock + $urandom_range(0, 200);
      else if (pick < 88) sim_clock = sim_clock + $urandom_range(0, 70) * len;
      else sim_clock = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 35) op = ttcs_pkg::OP_INTERRUPT;
      else if (pick < 70) op = ttcs_pkg::OP_SET_TIMEOUT;
      else if (pick < 95) op = ttcs_pkg::OP_QUERY;
      else op = OP_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 40) ticks = $urandom_range(1, 20);
      else if (pick < 50) ticks = ttcs_pkg::TICKS_FOREVER;
      else if (pick < 60) begin
        case ($urandom_range(0, 3))
          0: ticks = 32'd0;
          1: ticks = 32'hFFFF_FFFE;
          2: ticks = 32'h8000_0000;
          default: ticks = 32'h7FFF_FFFF;
        endcase
      end else if (pick < 80) ticks = $urandom();
      else ticks = tick_limit + $urandom_range(0, 3) - 1;
      add_event(op, sim_clock, ticks);
    end
  endtask

  task automatic run_phase(input logic [ttcs_pkg::CPT_W-1:0] cpt, input logic mode,
                           input int count);
    wait_idle();
    write_reg(ttcs_pkg::REG_TICK_LENGTH, cpt);
    write_reg(ttcs_pkg::REG_TICKLESS_MODE, {23'($urandom()), mode});
    @(negedge clk);
    add_events(count);
  endtask

  initial begin
    logic [ttcs_pkg::CPT_W-1:0] cpt;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    add_event(ttcs_pkg::OP_QUERY, 32'd0, 32'd0);
    add_event(ttcs_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'd159990, 32'd1);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'd0, ttcs_pkg::TICKS_FOREVER);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'd12345, 32'd0);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'd1, 32'd2);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'hFFFF_FFF0, 32'h7FFF_FFFF);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'h8000_0000, 32'h8000_0000);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'd500, 32'hFFFF_FFFE);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'd7, 32'd13421);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'hFFFF_FFFF, 32'd13423);
    add_event(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_event(ttcs_pkg::OP_INTERRUPT, 32'd0, 32'd0);
    add_event(ttcs_pkg::OP_INTERRUPT, 32'd160005, 32'd0);
    add_event(ttcs_pkg::OP_INTERRUPT, 32'hFFFF_FFFF, 32'd0);
    add_event(ttcs_pkg::OP_QUERY, 32'h5555_5555, 32'h5555_5555);
    add_event(ttcs_pkg::OP_SET_TIMEOUT, 32'hAAAA_AAAA, 32'd3);
    add_event(OP_UNUSED, 32'd0, 32'd0);
    add_event(ttcs_pkg::OP_INTERRUPT, 32'h1234_5678, 32'hAAAA_AAAA);

    run_phase(24'd1, 1'b1, 150);
    run_phase(24'hFF_FFFF, 1'b0, 150);
    run_phase(24'd0, 1'b1, 100);
    run_phase(24'hFF_FFFF, 1'b1, 150);
    run_phase(24'd1, 1'b0, 100);
    repeat (4) begin
      if ($urandom_range(0, 1) == 0) cpt = ttcs_pkg::CPT_W'($urandom_range(1, 2000));
      else cpt = ttcs_pkg::CPT_W'($urandom_range(1, 24'hFF_FFFF));
      run_phase(cpt, 1'($urandom_range(0, 1)), 100);
    end
    wait_idle();
    quiet = 1;
    run_phase(ttcs_pkg::CPT_RESET, 1'b1, 200);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
